// ===== rtl/shw_pkg.sv =====
// Shared types and constants for the sensor health watchdog.
// No dependencies; imported by every module of the block.
`default_nettype none

package shw_pkg;

   // sensor count and derived widths
   localparam int SENSORS = 8;
   localparam int IDX_W   = (SENSORS > 1) ? $clog2(SENSORS) : 1;
   localparam int ID_W    = 6;
   localparam int MASK_W  = 8;
   localparam int TIME_W  = 32;
   localparam int TMO_W   = 16;
   localparam int REC_W   = 8;
   localparam int ERR_W   = 16;

   // command queue between front and back
   localparam int QDEPTH  = 2;
   localparam int QPTR_W  = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
   localparam int QCNT_W  = $clog2(QDEPTH + 1);

   // request opcodes
   localparam logic [1:0] OP_SUCCESS = 2'd0;
   localparam logic [1:0] OP_FAILURE = 2'd1;
   localparam logic [1:0] OP_TICK    = 2'd2;

   // csr indexes
   localparam logic [1:0] CSR_TIMEOUT  = 2'd0;
   localparam logic [1:0] CSR_MAX_REC  = 2'd1;
   localparam logic [1:0] CSR_EN_MASK  = 2'd2;

   localparam logic [TMO_W-1:0]  TIMEOUT_RST = 16'd3000;
   localparam logic [REC_W-1:0]  MAX_REC_RST = 8'd5;
   localparam logic [MASK_W-1:0] EN_MASK_RST = 8'hFF;

   typedef enum logic [1:0] {
      HEALTH_OK        = 2'd0,
      HEALTH_WARNING   = 2'd1,
      HEALTH_RECOVERY  = 2'd2,
      HEALTH_PERMANENT = 2'd3
   } health_type;

   typedef enum logic [1:0] {
      CMD_SUCCESS = 2'd0,
      CMD_FAILURE = 2'd1,
      CMD_TICK    = 2'd2,
      CMD_BAD_ID  = 2'd3
   } cmd_kind_type;

   typedef enum logic {
      BK_IDLE = 1'b0,
      BK_WALK = 1'b1
   } back_state_type;

   typedef struct packed {
      cmd_kind_type    kind;
      logic [ID_W-1:0] id;
   } cmd_type;

   typedef struct packed {
      logic [TMO_W-1:0]  timeout_ms;
      logic [REC_W-1:0]  max_recoveries;
      logic [MASK_W-1:0] enable_mask;
   } cfg_type;

   typedef struct packed {
      logic [ID_W-1:0]  sensor_index;
      health_type       health;
      logic [REC_W-1:0] recoveries_done;
      logic [ERR_W-1:0] errors_seen;
      logic             reset_request;
      logic             bad_id;
      logic             last;
   } rsp_type;

   // sensors past the mask width have no enable bit and are always checked
   function automatic logic sensor_enabled(logic [ID_W-1:0] idx, logic [MASK_W-1:0] mask);
      return (idx >= ID_W'(MASK_W)) || mask[idx[2:0]];
   endfunction

endpackage

`default_nettype wire

// ===== rtl/sensor_health_watchdog.sv =====
// Sensor health watchdog top level: csr bank, front end, command queue, back end.
// Depends on shw_pkg, shw_front, shw_queue, shw_back.
//
// The watchdog tracks SENSORS sensors (8). Each request transaction is a
// success report, a failure report, or a one-millisecond tick. A report
// yields exactly one response transaction for the addressed sensor (or a
// bad_id response when the id is out of range); a tick yields one response
// per sensor in index order, the final one flagged by last, with
// reset_request set for every enabled, not permanently failed sensor
// that timed out on that tick. Opcode 3 is consumed and yields nothing.
// The front end decodes requests into a two-entry command queue, so
// requests keep flowing while the back end is stalled on the response
// side, until the queue fills. The back end touches one sensor entry per
// cycle while the response side does not stall; a tick first advances
// the millisecond counter, then walks every sensor in index order. The
// csr port is always ready; write registers only while the block is idle.
`default_nettype none

module sensor_health_watchdog import shw_pkg::*; (
   input  wire logic             clock,
   input  wire logic             reset,

   // request channel
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire logic [1:0]       req_op,
   input  wire logic [ID_W-1:0]  req_sensor_id,

   // response channel
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output logic [ID_W-1:0]       rsp_sensor_index,
   output logic [1:0]            rsp_health,
   output logic [REC_W-1:0]      rsp_recoveries_done,
   output logic [ERR_W-1:0]      rsp_errors_seen,
   output logic                  rsp_reset_request,
   output logic                  rsp_bad_id,
   output logic                  rsp_last,

   // csr write channel
   input  wire logic             csr_valid,
   output logic                  csr_ready,
   input  wire logic [1:0]       csr_index,
   input  wire logic [TMO_W-1:0] csr_data
);

   cfg_type cfg_ff, cfg_in;
   logic    csr_write;

   logic    q_full, q_push, q_pop, q_head_valid;
   cmd_type q_cmd, q_head;
   rsp_type rsp;

   // csr bank: no side effects, so always ready
   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_TIMEOUT: cfg_in.timeout_ms     = csr_data;
            CSR_MAX_REC: cfg_in.max_recoveries = csr_data[REC_W-1:0];
            CSR_EN_MASK: cfg_in.enable_mask    = csr_data[MASK_W-1:0];
            default:     cfg_in = cfg_ff;  // unmapped index: write dropped
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.timeout_ms     <= TIMEOUT_RST;
         cfg_ff.max_recoveries <= MAX_REC_RST;
         cfg_ff.enable_mask    <= EN_MASK_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // front end: accept and classify
   shw_front u_front (
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_op        (req_op),
      .req_sensor_id (req_sensor_id),
      .q_full        (q_full),
      .q_push        (q_push),
      .q_cmd         (q_cmd)
   );

   // decouples front from back
   shw_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_cmd   (q_cmd),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (q_head_valid),
      .head_cmd   (q_head)
   );

   // back end: state update, tick walk, response register
   shw_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .cmd_valid (q_head_valid),
      .cmd       (q_head),
      .cmd_pop   (q_pop),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp       (rsp)
   );

   assign rsp_sensor_index    = rsp.sensor_index;
   assign rsp_health          = rsp.health;
   assign rsp_recoveries_done = rsp.recoveries_done;
   assign rsp_errors_seen     = rsp.errors_seen;
   assign rsp_reset_request   = rsp.reset_request;
   assign rsp_bad_id          = rsp.bad_id;
   assign rsp_last            = rsp.last;

endmodule

`default_nettype wire

// ===== rtl/shw_front.sv =====
// Front end: accepts request transactions and classifies them into commands.
// Depends on shw_pkg.
`default_nettype none

module shw_front import shw_pkg::*; (
   input  wire logic            req_valid,
   output logic                 req_stall,
   input  wire logic [1:0]      req_op,
   input  wire logic [ID_W-1:0] req_sensor_id,
   input  wire logic            q_full,
   output logic                 q_push,
   output cmd_type              q_cmd
);

   logic accept;
   logic id_ok;

   assign req_stall = q_full;
   assign accept    = req_valid && !req_stall;
   assign id_ok     = ({1'b0, req_sensor_id} < (ID_W+1)'(SENSORS));

   always_comb begin
      q_push     = 1'b0;
      q_cmd.id   = req_sensor_id;
      q_cmd.kind = CMD_TICK;
      unique case (req_op)
         OP_SUCCESS: begin
            q_push     = accept;
            q_cmd.kind = id_ok ? CMD_SUCCESS : CMD_BAD_ID;
         end
         OP_FAILURE: begin
            q_push     = accept;
            q_cmd.kind = id_ok ? CMD_FAILURE : CMD_BAD_ID;
         end
         OP_TICK: begin
            q_push     = accept;
            q_cmd.kind = CMD_TICK;
         end
         default: begin
            // unused opcode: consumed, no command
            q_push = 1'b0;
         end
      endcase
   end

endmodule

`default_nettype wire

// ===== rtl/shw_queue.sv =====
// Short command FIFO between front end and back end.
// Depends on shw_pkg.
`default_nettype none

module shw_queue import shw_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  wire cmd_type push_cmd,
   output logic         full,
   input  wire logic    pop,
   output logic         head_valid,
   output cmd_type      head_cmd
);

   cmd_type            store_ff [QDEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]  count_ff, count_in;
   logic               do_push, do_pop;

   assign full       = (count_ff == QCNT_W'(QDEPTH));
   assign head_valid = (count_ff != '0);
   assign head_cmd   = store_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         store_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/shw_back.sv =====
// Back end: executes commands on per-sensor state, walks sensors on a tick,
// and holds the result register. Depends on shw_pkg.
`default_nettype none

module shw_back import shw_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire cfg_type cfg,
   input  wire logic    cmd_valid,
   input  wire cmd_type cmd,
   output logic         cmd_pop,
   input  wire logic    rsp_stall,
   output logic         rsp_valid,
   output rsp_type      rsp
);

   back_state_type    state_ff, state_in;
   logic [IDX_W-1:0]  ptr_ff, ptr_in;
   logic [TIME_W-1:0] now_ff, now_in;

   logic [TIME_W-1:0] last_good_ff [SENSORS];
   logic [ERR_W-1:0]  err_ff       [SENSORS];
   logic [REC_W-1:0]  rec_ff       [SENSORS];
   health_type        health_ff    [SENSORS];

   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff, rsp_in;

   logic [IDX_W-1:0]  sel;
   logic [TIME_W-1:0] cur_last, age;
   logic [ERR_W-1:0]  cur_err;
   logic [REC_W-1:0]  cur_rec, rec_inc;
   health_type        cur_health;
   logic              out_free, timed_out, enabled;

   logic              wr_en, emit;
   logic [TIME_W-1:0] new_last;
   logic [ERR_W-1:0]  new_err;
   logic [REC_W-1:0]  new_rec;
   health_type        new_health;
   rsp_type           emit_rsp;

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // one sensor entry is looked at per cycle
   assign sel        = (state_ff == BK_WALK) ? ptr_ff : cmd.id[IDX_W-1:0];
   assign cur_last   = last_good_ff[sel];
   assign cur_err    = err_ff[sel];
   assign cur_rec    = rec_ff[sel];
   assign cur_health = health_ff[sel];

   assign age       = now_ff - cur_last;
   assign timed_out = age > TIME_W'(cfg.timeout_ms);
   assign rec_inc   = (cur_rec == '1) ? cur_rec : cur_rec + 1'b1;
   assign enabled   = sensor_enabled(ID_W'(sel), cfg.enable_mask);

   always_comb begin
      state_in   = state_ff;
      ptr_in     = ptr_ff;
      now_in     = now_ff;
      cmd_pop    = 1'b0;
      wr_en      = 1'b0;
      emit       = 1'b0;
      new_last   = cur_last;
      new_err    = cur_err;
      new_rec    = cur_rec;
      new_health = cur_health;

      emit_rsp.sensor_index    = ID_W'(sel);
      emit_rsp.health          = new_health;
      emit_rsp.recoveries_done = new_rec;
      emit_rsp.errors_seen     = new_err;
      emit_rsp.reset_request   = 1'b0;
      emit_rsp.bad_id          = 1'b0;
      emit_rsp.last            = 1'b1;

      unique case (state_ff)
         BK_IDLE: begin
            if (cmd_valid) begin
               unique case (cmd.kind)
                  CMD_TICK: begin
                     cmd_pop  = 1'b1;
                     now_in   = now_ff + 1'b1;
                     ptr_in   = '0;
                     state_in = BK_WALK;
                  end
                  CMD_SUCCESS: begin
                     if (out_free) begin
                        cmd_pop  = 1'b1;
                        wr_en    = 1'b1;
                        emit     = 1'b1;
                        new_last = now_ff;
                        new_err  = '0;
                        if (cur_health == HEALTH_WARNING ||
                            cur_health == HEALTH_RECOVERY) begin
                           new_health = HEALTH_OK;
                        end
                     end
                  end
                  CMD_FAILURE: begin
                     if (out_free) begin
                        cmd_pop = 1'b1;
                        wr_en   = 1'b1;
                        emit    = 1'b1;
                        new_err = (cur_err == '1) ? cur_err : cur_err + 1'b1;
                     end
                  end
                  CMD_BAD_ID: begin
                     if (out_free) begin
                        cmd_pop = 1'b1;
                        emit    = 1'b1;
                     end
                  end
                  default: begin
                     cmd_pop = 1'b0;
                  end
               endcase
            end
         end
         BK_WALK: begin
            if (out_free) begin
               emit = 1'b1;
               if (enabled && cur_health != HEALTH_PERMANENT && timed_out) begin
                  wr_en      = 1'b1;
                  new_last   = now_ff;
                  new_rec    = rec_inc;
                  new_health = (rec_inc >= cfg.max_recoveries) ? HEALTH_PERMANENT
                                                                : HEALTH_RECOVERY;
                  emit_rsp.reset_request = 1'b1;
               end
               if (ptr_ff == IDX_W'(SENSORS - 1)) begin
                  state_in = BK_IDLE;
               end else begin
                  emit_rsp.last = 1'b0;
                  ptr_in        = ptr_ff + 1'b1;
               end
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase

      emit_rsp.health          = new_health;
      emit_rsp.recoveries_done = new_rec;
      emit_rsp.errors_seen     = new_err;

      // bad id: report the raw id with bad_id and last set, sensor fields zero
      if (state_ff == BK_IDLE && cmd.kind == CMD_BAD_ID) begin
         emit_rsp.sensor_index    = cmd.id;
         emit_rsp.health          = HEALTH_OK;
         emit_rsp.recoveries_done = '0;
         emit_rsp.errors_seen     = '0;
         emit_rsp.reset_request   = 1'b0;
         emit_rsp.bad_id          = 1'b1;
         emit_rsp.last            = 1'b1;
      end

      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_in       = emit_rsp;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         ptr_ff       <= '0;
         now_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < SENSORS; i++) begin
            last_good_ff[i] <= '0;
            err_ff[i]       <= '0;
            rec_ff[i]       <= '0;
            health_ff[i]    <= HEALTH_OK;
         end
      end else begin
         state_ff     <= state_in;
         ptr_ff       <= ptr_in;
         now_ff       <= now_in;
         rsp_valid_ff <= rsp_valid_in;
         if (wr_en) begin
            last_good_ff[sel] <= new_last;
            err_ff[sel]       <= new_err;
            rec_ff[sel]       <= new_rec;
            health_ff[sel]    <= new_health;
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

endmodule

`default_nettype wire

// ===== rtl/shw_checker.sv =====
// Port-level assertions for the sensor health watchdog, bound to the top level.
// Depends on shw_pkg and sensor_health_watchdog.
`default_nettype none

module shw_checker import shw_pkg::*; (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             rsp_valid,
   input wire logic             rsp_stall,
   input wire logic [ID_W-1:0]  rsp_sensor_index,
   input wire logic [1:0]       rsp_health,
   input wire logic [REC_W-1:0] rsp_recoveries_done,
   input wire logic [ERR_W-1:0] rsp_errors_seen,
   input wire logic             rsp_reset_request,
   input wire logic             rsp_bad_id,
   input wire logic             rsp_last
);

   // stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_sensor_index) &&
         $stable(rsp_health) && $stable(rsp_errors_seen) && $stable(rsp_last))
      else $error("stalled response changed");

   // bad id response carries no sensor state and ends the transaction
   a_bad_id: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_bad_id |-> rsp_last && !rsp_reset_request &&
         rsp_health == HEALTH_OK && rsp_recoveries_done == '0 && rsp_errors_seen == '0)
      else $error("bad id response with sensor data");

   // a reset request always leaves the sensor in recovery or permanent failure
   a_reset_req: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_reset_request |-> rsp_recoveries_done != '0 &&
         (rsp_health == HEALTH_RECOVERY || rsp_health == HEALTH_PERMANENT))
      else $error("reset request with wrong health");

   // nothing comes out right after reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind sensor_health_watchdog shw_checker u_shw_checker (.*);

`default_nettype wire
